// ----- hw/rtl/spherical_shell_point_sampler_defines.svh -----
// assertion macros for the spherical shell point sampler
`ifndef SPHERICAL_SHELL_POINT_SAMPLER_DEFINES_SVH
`define SPHERICAL_SHELL_POINT_SAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SSPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssps: same-cycle check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define SSPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssps: next-cycle check failed");

`endif

// ----- hw/rtl/ssps_pkg.sv -----
// shared types and constants of the spherical shell point sampler
package ssps_pkg;

	localparam int COORD_FRAC_BITS_DEF  = 15;
	localparam int RADIUS_FRAC_BITS_DEF = 8;

	// square root of (1 - s) in q.30: one result bit per stage
	localparam int SQ_DIGITS = 31;
	localparam int SQ_RAD_W  = 2 * SQ_DIGITS;
	// cube root of u * 2^15: one result bit per stage
	localparam int CB_DIGITS = 21;
	localparam int CB_RAD_W  = 3 * CB_DIGITS;

	localparam int PREP_STAGES = 5;
	localparam int MATH_STAGES = 3;

	localparam int QDEPTH = 4;
	localparam int S_W    = 31;
	localparam logic [S_W-1:0] ONE_Q30 = S_W'(1) << 30;

	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_SHELL_MODE = 2'd0;
	localparam logic [1:0] REG_RADIUS_MIN = 2'd1;
	localparam logic [1:0] REG_RADIUS_MAX = 2'd2;

	typedef struct packed {
		logic signed [15:0] rand_a;
		logic signed [15:0] rand_b;
		logic [15:0]        rand_radial;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
	} out_item_t;

	// accepted pair waiting for the back end
	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic [15:0]        frac;
		logic [S_W-1:0]     s;
	} qent_t;

	typedef struct packed {
		logic        shell_mode;
		logic [15:0] radius_min;
		logic [15:0] radius_max;
	} cfg_t;

	typedef struct packed {
		logic issue;
		logic busy;
	} bstat_t;

endpackage

// ----- hw/rtl/spherical_shell_point_sampler.sv -----
// Spherical shell point sampler top level. Takes one random set per cycle unless full,
// and gives one point per cycle while pop drains the result register, for every pair
// inside the unit disk; pairs outside are dropped in the front end. An item passes one
// square stage and one queue slot in the front, 35 back-end stages whose length is set
// by the 31-stage square root pipeline (one root bit per stage; the 21-stage cube root
// runs beside it), and the result register. A four-entry queue between front and back
// and the result register let either side stall without losing an item. Configuration
// is written over APB at byte addresses 0 (shell_mode), 4 (radius_min), 8 (radius_max).
`include "spherical_shell_point_sampler_defines.svh"

module spherical_shell_point_sampler #(
	parameter int COORD_FRAC_BITS  = ssps_pkg::COORD_FRAC_BITS_DEF,
	parameter int RADIUS_FRAC_BITS = ssps_pkg::RADIUS_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  ssps_pkg::in_item_t            sample,
	output logic                          empty,
	input  logic                          pop,
	output ssps_pkg::out_item_t           point,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic        shell_mode_q;
	logic [15:0] radius_min_q, radius_max_q;
	logic        cfg_wr;
	ssps_pkg::cfg_t   cfg;
	ssps_pkg::qent_t  head;
	ssps_pkg::bstat_t stat;
	logic head_valid;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shell_mode_q <= 1'b0;
			radius_min_q <= 16'd256;
			radius_max_q <= 16'd256;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				ssps_pkg::REG_SHELL_MODE: shell_mode_q <= pwdata[0];
				ssps_pkg::REG_RADIUS_MIN: radius_min_q <= pwdata[15:0];
				ssps_pkg::REG_RADIUS_MAX: radius_max_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ssps_pkg::REG_SHELL_MODE: prdata = {31'b0, shell_mode_q};
			ssps_pkg::REG_RADIUS_MIN: prdata = {16'b0, radius_min_q};
			ssps_pkg::REG_RADIUS_MAX: prdata = {16'b0, radius_max_q};
			default:                  prdata = '0;
		endcase
	end

	assign cfg = '{shell_mode: shell_mode_q, radius_min: radius_min_q,
		radius_max: radius_max_q};

	ssps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.sample     (sample),
		.full       (full),
		.pop        (stat.issue),
		.head       (head),
		.head_valid (head_valid)
	);

	ssps_back #(
		.COORD_FRAC_BITS  (COORD_FRAC_BITS),
		.RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.stat       (stat),
		.empty      (empty),
		.pop        (pop),
		.point      (point)
	);

	// an issued item is in flight on the next cycle
	`SSPS_ASSERT_NEXT(a_issue_in_flight, stat.issue, stat.busy)
	// a held result freezes the back end
	`SSPS_ASSERT_SAME(a_stall_no_issue, !empty && !pop, !stat.issue)
	// draining the last result leaves the block empty
	`SSPS_ASSERT_NEXT(a_drain_empty, !stat.busy && !head_valid && !empty && pop, empty)

endmodule

// ----- hw/rtl/ssps_front.sv -----
// front end: squares the pair, drops points outside the unit disk, queues the rest
module ssps_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssps_pkg::in_item_t sample,
	output logic             full,
	input  logic             pop,
	output ssps_pkg::qent_t  head,
	output logic             head_valid
);

	localparam int PW = $clog2(ssps_pkg::QDEPTH);
	localparam int CW = PW + 1;

	logic accept;
	logic v_s1;
	logic signed [15:0] a_s1, b_s1;
	logic [15:0] frac_s1;
	logic [30:0] aa_s1, bb_s1;
	logic signed [31:0] sqa, sqb;
	logic [31:0] s_sum;
	logic keep, wr;
	logic [CW:0] used;

	ssps_pkg::qent_t mem_q [ssps_pkg::QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign accept = push && !full;
	assign sqa = sample.rand_a * sample.rand_a;
	assign sqb = sample.rand_b * sample.rand_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1    <= sample.rand_a;
			b_s1    <= sample.rand_b;
			frac_s1 <= sample.rand_radial;
			aa_s1   <= sqa[30:0];
			bb_s1   <= sqb[30:0];
		end
	end

	assign s_sum = {1'b0, aa_s1} + {1'b0, bb_s1};
	assign keep  = s_sum <= {1'b0, ssps_pkg::ONE_Q30};
	assign wr    = v_s1 && keep;

	// an item still in the square stage holds a queue slot
	assign used = {1'b0, cnt_q} + (CW + 1)'(v_s1);
	assign full = used >= (CW + 1)'(ssps_pkg::QDEPTH);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= '{a: a_s1, b: b_s1, frac: frac_s1, s: s_sum[30:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(pop);
		end
	end

	assign head       = mem_q[rptr_q];
	assign head_valid = cnt_q != '0;

endmodule

// ----- hw/rtl/ssps_sqrt.sv -----
// pipelined digit-by-digit integer square root, one result bit per stage
module ssps_sqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ssps_pkg::SQ_RAD_W-1:0]    rad,
	output logic [ssps_pkg::SQ_DIGITS-1:0]   root
);

	localparam int N  = ssps_pkg::SQ_DIGITS;
	localparam int VW = ssps_pkg::SQ_RAD_W;
	localparam int RW = N + 3;

	logic [RW-1:0] rem_q  [N-1];
	logic [VW-1:0] rad_q  [N-1];
	logic [N-1:0]  root_q [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] rem_i;
		logic [VW-1:0] rad_i;
		logic [N-1:0]  root_i;
		logic [RW+1:0] cur, trial;
		logic take;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign rad_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_q[k-1];
			assign rad_i  = rad_q[k-1];
			assign root_i = root_q[k-1];
		end

		assign cur   = {rem_i, rad_i[VW-1-2*k -: 2]};
		assign trial = (RW + 2)'({root_i, 2'b01});
		assign take  = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[k] <= {root_i[N-2:0], take};
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? RW'(cur - trial) : RW'(cur);
					rad_q[k] <= rad_i;
				end
			end
		end
	end

	assign root = root_q[N-1];

endmodule

// ----- hw/rtl/ssps_cbrt.sv -----
// pipelined digit-by-digit integer cube root, one result bit per stage
module ssps_cbrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ssps_pkg::CB_RAD_W-1:0]    rad,
	output logic [ssps_pkg::CB_DIGITS-1:0]   root
);

	localparam int N  = ssps_pkg::CB_DIGITS;
	localparam int VW = ssps_pkg::CB_RAD_W;
	localparam int SW = 2 * N;
	localparam int RW = SW + 3;

	logic [RW-1:0] rem_q [N-1];
	logic [VW-1:0] rad_q [N-1];
	logic [SW-1:0] sq_q  [N-1];
	logic [N-1:0]  y_q   [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] rem_i;
		logic [VW-1:0] rad_i;
		logic [SW-1:0] sq_i;
		logic [N-1:0]  y_i;
		logic [RW+2:0] cur, need, sq_w, y_w;
		logic take;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign rad_i = rad;
			assign sq_i  = '0;
			assign y_i   = '0;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign rad_i = rad_q[k-1];
			assign sq_i  = sq_q[k-1];
			assign y_i   = y_q[k-1];
		end

		// (2y+1)^3 - (2y)^3 = 12 y^2 + 6 y + 1, with y^2 kept alongside
		assign sq_w = (RW + 3)'(sq_i);
		assign y_w  = (RW + 3)'(y_i);
		assign cur  = {rem_i, rad_i[VW-1-3*k -: 3]};
		assign need = (sq_w << 3) + (sq_w << 2) + (y_w << 2) + (y_w << 1) + (RW + 3)'(1);
		assign take = cur >= need;

		always_ff @(posedge clk) begin
			if (en) begin
				y_q[k] <= {y_i[N-2:0], take};
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? RW'(cur - need) : RW'(cur);
					rad_q[k] <= rad_i;
					sq_q[k]  <= take ? (sq_i << 2) + (SW'(y_i) << 2) + SW'(1) : (sq_i << 2);
				end
			end
		end
	end

	assign root = y_q[N-1];

endmodule

// ----- hw/rtl/ssps_back.sv -----
// back end: radius pick, root pipelines, scaling, rounding, saturation and the result register
module ssps_back #(
	parameter int COORD_FRAC_BITS  = ssps_pkg::COORD_FRAC_BITS_DEF,
	parameter int RADIUS_FRAC_BITS = ssps_pkg::RADIUS_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssps_pkg::cfg_t      cfg,
	input  ssps_pkg::qent_t     head,
	input  logic                head_valid,
	output ssps_pkg::bstat_t    stat,
	output logic                empty,
	input  logic                pop,
	output ssps_pkg::out_item_t point
);

	localparam int SQ_END = 1 + ssps_pkg::SQ_DIGITS;
	localparam int CB_END = ssps_pkg::PREP_STAGES + ssps_pkg::CB_DIGITS;
	localparam int CB_PAD = SQ_END - CB_END;
	localparam int NSTG   = SQ_END + ssps_pkg::MATH_STAGES;
	localparam int NC     = ssps_pkg::CB_DIGITS;
	localparam int PW     = 34;
	localparam int PRW    = PW + NC + 1;
	localparam int KSF    = 30 - COORD_FRAC_BITS;
	localparam int KSH    = 35 + RADIUS_FRAC_BITS - COORD_FRAC_BITS;
	localparam logic signed [PRW-1:0] HALF_F = (PRW'(1) <<< KSF) >>> 1;
	localparam logic signed [PRW-1:0] HALF_H = (PRW'(1) <<< KSH) >>> 1;
	localparam logic signed [PRW-1:0] OMAX   = PRW'(8388607);
	localparam logic signed [PRW-1:0] OMIN   = -(PRW'(8388608));

	typedef struct packed {
		logic signed [15:0]         a;
		logic signed [15:0]         b;
		logic [ssps_pkg::S_W-1:0]   s;
		logic                       shell;
	} sb_t;

	function automatic logic signed [23:0] fin(input logic signed [PRW-1:0] v, input logic shell);
		logic signed [PRW-1:0] r;
		r = shell ? (v + HALF_H) >>> KSH : (v + HALF_F) >>> KSF;
		if (r > OMAX) begin
			r = OMAX;
		end else if (r < OMIN) begin
			r = OMIN;
		end
		return r[23:0];
	endfunction

	logic adv, issue;
	logic [NSTG-1:0] vld_q;
	logic out_full_q;
	ssps_pkg::out_item_t point_q;

	assign adv   = !out_full_q || pop;
	assign issue = adv && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			out_full_q <= 1'b0;
		end else if (adv) begin
			vld_q      <= {vld_q[NSTG-2:0], issue};
			out_full_q <= vld_q[NSTG-1];
		end
	end

	// sideband line from s1 to the end of the square root
	sb_t sb_q [SQ_END];

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= '{a: head.a, b: head.b, s: head.s, shell: cfg.shell_mode};
			for (int i = 1; i < SQ_END; i++) begin
				sb_q[i] <= sb_q[i-1];
			end
		end
	end

	// radius pick: cubes of the radii, then u between them
	logic [ssps_pkg::S_W-1:0] d_s1;
	logic [15:0] frac_s1, frac_s2, frac_s3;
	logic [31:0] rmin_sq_s1, rmax_sq_s1;
	logic [47:0] c3min_s2, c3max_s2;
	logic [47:0] c3min_s3, diff_s3, c3min_s4, u_s5;
	logic ge_s3, ge_s4;
	logic [63:0] prod_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1       <= ssps_pkg::ONE_Q30 - head.s;
			frac_s1    <= head.frac;
			rmin_sq_s1 <= cfg.radius_min * cfg.radius_min;
			rmax_sq_s1 <= cfg.radius_max * cfg.radius_max;
			frac_s2    <= frac_s1;
			c3min_s2   <= rmin_sq_s1 * cfg.radius_min;
			c3max_s2   <= rmax_sq_s1 * cfg.radius_max;
			frac_s3    <= frac_s2;
			ge_s3      <= c3max_s2 >= c3min_s2;
			diff_s3    <= (c3max_s2 >= c3min_s2) ? c3max_s2 - c3min_s2 : c3min_s2 - c3max_s2;
			c3min_s3   <= c3min_s2;
			prod_s4    <= frac_s3 * diff_s3;
			ge_s4      <= ge_s3;
			c3min_s4   <= c3min_s3;
			u_s5       <= ge_s4 ? c3min_s4 + prod_s4[63:16] : c3min_s4 - prod_s4[63:16];
		end
	end

	logic [ssps_pkg::SQ_DIGITS-1:0] q;
	logic [NC-1:0] c_raw;
	logic [NC-1:0] c_dl [CB_PAD];

	ssps_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  ({1'b0, d_s1, 30'b0}),
		.root (q)
	);

	ssps_cbrt u_cbrt (
		.clk  (clk),
		.en   (adv),
		.rad  ({u_s5, 15'b0}),
		.root (c_raw)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			c_dl[0] <= c_raw;
			for (int i = 1; i < CB_PAD; i++) begin
				c_dl[i] <= c_dl[i-1];
			end
		end
	end

	// surface point, then optional radial scaling
	sb_t sb_m;
	logic signed [48:0] mx_s33, my_s33, mx_r, my_r;
	logic signed [32:0] z_s33;
	logic shell_s33, shell_s34, shell_s35;
	logic [NC-1:0] c_s33, c_s34;
	logic signed [PW-1:0] x_s34, y_s34, z_s34;
	logic signed [PRW-1:0] px_s35, py_s35, pz_s35;

	assign sb_m = sb_q[SQ_END-1];
	assign mx_r = (mx_s33 + 49'sd16384) >>> 15;
	assign my_r = (my_s33 + 49'sd16384) >>> 15;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s33    <= $signed({sb_m.a, 1'b0}) * $signed({1'b0, q});
			my_s33    <= $signed({sb_m.b, 1'b0}) * $signed({1'b0, q});
			z_s33     <= $signed({2'b00, ssps_pkg::ONE_Q30}) - $signed({1'b0, sb_m.s, 1'b0});
			shell_s33 <= sb_m.shell;
			c_s33     <= c_dl[CB_PAD-1];

			x_s34     <= mx_r[PW-1:0];
			y_s34     <= my_r[PW-1:0];
			z_s34     <= {z_s33[32], z_s33};
			shell_s34 <= shell_s33;
			c_s34     <= c_s33;

			shell_s35 <= shell_s34;
			if (shell_s34) begin
				px_s35 <= x_s34 * $signed({1'b0, c_s34});
				py_s35 <= y_s34 * $signed({1'b0, c_s34});
				pz_s35 <= z_s34 * $signed({1'b0, c_s34});
			end else begin
				px_s35 <= {{(PRW - PW){x_s34[PW-1]}}, x_s34};
				py_s35 <= {{(PRW - PW){y_s34[PW-1]}}, y_s34};
				pz_s35 <= {{(PRW - PW){z_s34[PW-1]}}, z_s34};
			end

			point_q.point_x <= fin(px_s35, shell_s35);
			point_q.point_y <= fin(py_s35, shell_s35);
			point_q.point_z <= fin(pz_s35, shell_s35);
		end
	end

	assign point      = point_q;
	assign empty      = !out_full_q;
	assign stat.issue = issue;
	assign stat.busy  = |vld_q;

endmodule
